[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, sampled on the rising clock, off while reset is low
`define LPHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication check
`define LPHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/lpht_pkg.sv]
package lpht_pkg;

    // table geometry
    localparam int SLOT_COUNT  = 1024;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int FULL_LIMIT  = SLOT_COUNT * 3 / 4;
    localparam int VALUE_WIDTH = 32;
    localparam int KEY_W       = 64;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;

    // key mixer
    localparam int              MIX_SHIFT = 33;
    localparam logic [KEY_W-1:0] MIX_MULT = 64'hff51afd7ed558ccd;

    // command queue between front and back, power of two
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND     = 2'd0,
        ACT_FIND_INS = 2'd1,
        ACT_ASSIGN   = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    // hashed command handed from front to back
    typedef struct packed {
        t_action                  action;
        logic [KEY_W-1:0]         key;
        logic [VALUE_WIDTH-1:0]   value;
        logic [SLOT_W-1:0]        home;
    } t_cmd;

    // one slot of the table memory
    typedef struct packed {
        logic                     used;
        logic [KEY_W-1:0]         key;
        logic [VALUE_WIDTH-1:0]   value;
    } t_entry;

    typedef struct packed {
        t_status                  status;
        logic [VALUE_WIDTH-1:0]   value;
        logic [SLOT_W-1:0]        slot;
    } t_result;

    // command queue status
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

[rtl/core/lpht_front.sv]
module lpht_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_hold,
    input  logic [lpht_pkg::ACTION_W-1:0]    i_action,
    input  logic [lpht_pkg::KEY_W-1:0]       i_key,
    input  logic [lpht_pkg::VALUE_WIDTH-1:0] i_new_value,
    output logic                             o_full,
    input  lpht_pkg::t_q_stat                i_q,
    output logic                             o_cmd_push,
    output lpht_pkg::t_cmd                   o_cmd
);
    import lpht_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_FIN  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate                r_state, n_state;
    logic [1:0]             r_step;
    t_action                r_action;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [KEY_W-1:0]       r_k1;
    logic [KEY_W-1:0]       r_prod;
    logic [KEY_W-1:0]       r_acc;

    logic                   w_take;
    logic                   w_push;
    logic [31:0]            w_mul_a, w_mul_b;
    logic [KEY_W-1:0]       w_prod;
    logic [KEY_W-1:0]       w_mix;

    // handshake: a new beat may enter while the previous command leaves
    assign w_push     = (r_state == F_PUSH) && !i_q.full;
    assign o_full     = i_hold || !((r_state == F_IDLE) || w_push);
    assign w_take     = i_push && !o_full;
    assign o_cmd_push = w_push;

    // shared 32x32 multiplier, low and high halves over three steps
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = r_k1[31:0];
                w_mul_b = MIX_MULT[31:0];
            end
            2'd1: begin
                w_mul_a = r_k1[63:32];
                w_mul_b = MIX_MULT[31:0];
            end
            default: begin
                w_mul_a = r_k1[31:0];
                w_mul_b = MIX_MULT[63:32];
            end
        endcase
    end
    assign w_prod = {32'b0, w_mul_a} * {32'b0, w_mul_b};

    // final xor-shift and home slot
    assign w_mix = r_acc ^ (r_acc >> MIX_SHIFT);
    assign o_cmd = '{action: r_action, key: r_key, value: r_value,
                     home: w_mix[SLOT_W-1:0]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (w_take) n_state = F_MUL;
            F_MUL:  if (r_step == 2'd2) n_state = F_FIN;
            F_FIN:  n_state = F_PUSH;
            F_PUSH: begin
                if (w_push) n_state = w_take ? F_MUL : F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_step <= 2'd0;
            end else if (r_state == F_MUL) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    // beat capture and multiply accumulate
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= t_action'(i_action);
            r_key    <= i_key;
            r_value  <= i_new_value;
            r_k1     <= i_key ^ (i_key >> MIX_SHIFT);
        end
        if (r_state == F_MUL) begin
            r_prod <= w_prod;
        end
        if ((r_state == F_MUL) && (r_step == 2'd1)) begin
            r_acc <= r_prod;
        end else if (((r_state == F_MUL) && (r_step == 2'd2)) || (r_state == F_FIN)) begin
            r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
        end
    end

endmodule

[rtl/core/lpht_fifo.sv]
`include "assert_macros.svh"

module lpht_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpht_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output lpht_pkg::t_cmd    o_cmd,
    output lpht_pkg::t_q_stat o_stat
);
    import lpht_pkg::*;

    t_cmd              r_buf [CMDQ_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_stat.full  = (r_count == QCNT_W'(CMDQ_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_stat.valid;
    assign o_cmd        = r_buf[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wr] <= i_cmd;
    end

    `LPHT_ASSERT(a_q_level, r_count <= QCNT_W'(CMDQ_DEPTH), "command queue overfilled")
    `LPHT_ASSERT_IMPL(a_q_ptrs, r_count == '0, r_wr == r_rd, "empty queue with skewed pointers")

endmodule

[rtl/core/lpht_back.sv]
`include "assert_macros.svh"

module lpht_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpht_pkg::t_q_stat i_q,
    input  lpht_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_init_busy,
    output lpht_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_pop
);
    import lpht_pkg::*;

    typedef enum logic [2:0] {
        B_SWEEP = 3'b001,
        B_IDLE  = 3'b010,
        B_PROBE = 3'b100
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_cnt;
    logic              r_clr;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_count;
    t_result           r_res;
    logic              r_res_valid;
    t_entry            r_slot_mem [SLOT_COUNT];
    t_entry            r_rd;

    logic              w_res_free;
    logic              w_done;
    logic              w_inc;
    logic              w_step;
    logic              w_we;
    logic [SLOT_W-1:0] w_rd_addr;
    t_entry            w_wd;
    t_result           w_res;
    logic              w_match;
    logic              w_last;
    logic              w_at_limit;

    assign w_res_free  = !r_res_valid || i_res_pop;
    assign o_cmd_pop   = (r_state == B_IDLE) && i_q.valid && w_res_free;
    assign o_init_busy = (r_state == B_SWEEP) && !r_clr;
    assign w_match     = r_rd.used && (r_rd.key == r_cmd.key);
    assign w_last      = (r_cnt == SLOT_W'(SLOT_COUNT - 1));
    assign w_at_limit  = (r_count >= CNT_W'(FULL_LIMIT));

    // sweep, probe decision and slot update
    always_comb begin
        n_state   = r_state;
        w_done    = 1'b0;
        w_inc     = 1'b0;
        w_step    = 1'b0;
        w_we      = 1'b0;
        w_rd_addr = i_cmd.home;
        w_wd      = '{used: 1'b1, key: r_cmd.key, value: r_cmd.value};
        w_res     = '{status: ST_MISS, value: '0, slot: '0};
        case (r_state)
            B_SWEEP: begin
                w_we = 1'b1;
                w_wd = '0;
                if (r_idx == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = B_IDLE;
                    if (r_clr) begin
                        w_done       = 1'b1;
                        w_res.status = ST_CLEARED;
                    end
                end
            end
            B_IDLE: begin
                if (o_cmd_pop) begin
                    n_state = (i_cmd.action == ACT_CLEAR) ? B_SWEEP : B_PROBE;
                end
            end
            B_PROBE: begin
                if (!r_rd.used) begin
                    // unused slot ends the chain
                    w_done = 1'b1;
                    if (r_cmd.action == ACT_FIND) begin
                        w_res.status = ST_MISS;
                    end else if (w_at_limit) begin
                        w_res.status = ST_FULL;
                    end else begin
                        w_we  = 1'b1;
                        w_inc = 1'b1;
                        if (r_cmd.action != ACT_ASSIGN) w_wd.value = '0;
                        w_res = '{status: ST_INSERTED, value: w_wd.value, slot: r_idx};
                    end
                end else if (w_match) begin
                    w_done = 1'b1;
                    if (r_cmd.action == ACT_ASSIGN) begin
                        w_we  = 1'b1;
                        w_res = '{status: ST_HIT, value: r_cmd.value, slot: r_idx};
                    end else begin
                        w_res = '{status: ST_HIT, value: r_rd.value, slot: r_idx};
                    end
                end else if (w_last) begin
                    // whole table walked without a free slot
                    w_done       = 1'b1;
                    w_res.status = (r_cmd.action == ACT_FIND) ? ST_MISS : ST_FULL;
                end else begin
                    w_step    = 1'b1;
                    w_rd_addr = r_idx + 1'b1;
                end
                if (w_done) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_SWEEP;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_clr       <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_SWEEP) begin
                r_idx <= r_idx + 1'b1;
            end else if (o_cmd_pop) begin
                r_idx <= (i_cmd.action == ACT_CLEAR) ? '0 : i_cmd.home;
                r_cnt <= '0;
                r_clr <= (i_cmd.action == ACT_CLEAR);
                if (i_cmd.action == ACT_CLEAR) r_count <= '0;
            end else if (w_step) begin
                r_idx <= r_idx + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_inc) r_count <= r_count + 1'b1;
            if (w_done) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (w_done)    r_res <= w_res;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_slot_mem[r_idx] <= w_wd;
        r_rd <= r_slot_mem[w_rd_addr];
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    `LPHT_ASSERT_IMPL(a_res_free, w_done, !r_res_valid, "result written over a waiting beat")
    `LPHT_ASSERT(a_fill_limit, r_count <= CNT_W'(FULL_LIMIT), "entry count beyond fill limit")
    `LPHT_ASSERT(a_res_hold, (r_res_valid && !i_res_pop) |=> (r_res_valid && $stable(r_res)),
                 "waiting result changed")

endmodule

[rtl/core/linear_probe_hash_table.sv]
// an accepted beat passes the front multiply steps, finish and push states and the
//   command queue; the probe unit then walks slots from the home slot to a chain end
// the front takes a new beat only when idle or pushing; its key multiplier is shared
// clear: one slot written per cycle on the single memory port
// reset: synchronous, active low; afterwards a sweep marks every slot
//   unused, full stays high during it
module linear_probe_hash_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [lpht_pkg::ACTION_W-1:0]    i_action,
    input  logic [lpht_pkg::KEY_W-1:0]       i_key,
    input  logic [lpht_pkg::VALUE_WIDTH-1:0] i_new_value,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [lpht_pkg::STATUS_W-1:0]    o_status,
    output logic [lpht_pkg::VALUE_WIDTH-1:0] o_found_value,
    output logic [lpht_pkg::SLOT_W-1:0]      o_slot_index
);
    import lpht_pkg::*;

    t_cmd    w_front_cmd, w_back_cmd;
    logic    w_q_push, w_q_pop;
    t_q_stat w_q_stat;
    logic    w_init_busy;
    t_result w_res;
    logic    w_res_valid;

    // hash front end
    lpht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_hold      (w_init_busy),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_full      (o_full),
        .i_q         (w_q_stat),
        .o_cmd_push  (w_q_push),
        .o_cmd       (w_front_cmd)
    );

    // command queue
    lpht_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_cmd   (w_back_cmd),
        .o_stat  (w_q_stat)
    );

    // probe and update back end
    lpht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_q_stat),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_init_busy (w_init_busy),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_pop   (i_pop)
    );

    // result side
    assign o_empty       = !w_res_valid;
    assign o_status      = w_res.status;
    assign o_found_value = w_res.value;
    assign o_slot_index  = w_res.slot;

endmodule

[tb/lpht_reply_checker.sv]
module lpht_reply_checker
    import lpht_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_full,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [VALUE_WIDTH-1:0] i_new_value,
    input  logic                   i_empty,
    input  logic                   i_pop,
    input  logic [STATUS_W-1:0]    i_status,
    input  logic [VALUE_WIDTH-1:0] i_found_value,
    input  logic [SLOT_W-1:0]      i_slot_index,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // shadow copy of the table
    logic                   slot_taken [SLOT_COUNT];
    logic [KEY_W-1:0]       slot_tag   [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] slot_data  [SLOT_COUNT];
    int                     entries;

    // replies predicted but not yet popped, oldest first
    t_result                due_replies [$];
    int                     errs = 0;

    // key scrambler: xor-shift, 64-bit multiply, xor-shift
    function automatic logic [KEY_W-1:0] key_mix(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] m;
        m = key ^ (key >> 33);
        m = m * 64'hff51_afd7_ed55_8ccd;
        m = m ^ (m >> 33);
        return m;
    endfunction

    // apply one command to the shadow table and return the reply it gives
    function automatic t_result table_apply(input t_action act,
                                            input logic [KEY_W-1:0] key,
                                            input logic [VALUE_WIDTH-1:0] nv);
        t_result           r;
        logic [KEY_W-1:0]  h;
        logic [SLOT_W-1:0] at;
        bit                matched;
        bit                vacant;
        r.status = ST_MISS;
        r.value  = '0;
        r.slot   = '0;
        if (act == ACT_CLEAR) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            entries  = 0;
            r.status = ST_CLEARED;
        end else begin
            // linear probe from the home slot, wrapping round
            h       = key_mix(key);
            at      = h[SLOT_W-1:0];
            matched = 1'b0;
            vacant  = 1'b0;
            for (int n = 0; n < SLOT_COUNT && !matched && !vacant; n++) begin
                if (!slot_taken[at])
                    vacant = 1'b1;
                else if (slot_tag[at] == key)
                    matched = 1'b1;
                else
                    at = at + 1'b1;
            end
            if (!matched && !vacant)
                at = '0;
            if (matched) begin
                if (act == ACT_ASSIGN)
                    slot_data[at] = nv;
                r.status = ST_HIT;
                r.value  = slot_data[at];
                r.slot   = at;
            end else if (act == ACT_FIND) begin
                r.status = ST_MISS;
            end else if (!vacant || entries * 4 >= SLOT_COUNT * 3) begin
                // no room for a new key
                r.status = ST_FULL;
            end else begin
                slot_taken[at] = 1'b1;
                slot_tag[at]   = key;
                slot_data[at]  = (act == ACT_ASSIGN) ? nv : '0;
                entries++;
                r.status = ST_INSERTED;
                r.value  = slot_data[at];
                r.slot   = at;
            end
        end
        return r;
    endfunction

    // predict on each accepted command beat, compare on each popped reply beat
    always @(posedge i_clk) begin : track
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            entries = 0;
            due_replies.delete();
        end else begin
            if (i_push && !i_full) begin
                pred        = table_apply(t_action'(i_action), i_key, i_new_value);
                due_replies = {due_replies, pred};
            end
            if (i_pop && !i_empty) begin
                if (due_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none got status %0d value %h slot %0d",
                             $time, i_status, i_found_value, i_slot_index);
                    errs++;
                end else begin
                    want = due_replies.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, i_status);
                        errs++;
                    end
                    if (i_found_value !== want.value) begin
                        $display("%0t: found_value expected %h got %h",
                                 $time, want.value, i_found_value);
                        errs++;
                    end
                    if (i_slot_index !== want.slot) begin
                        $display("%0t: slot_index expected %0d got %0d",
                                 $time, want.slot, i_slot_index);
                        errs++;
                    end
                end
            end
        end
        o_outstanding <= due_replies.size();
        o_mismatches  <= errs;
    end

endmodule

[tb/linear_probe_hash_table_test.sv]
module linear_probe_hash_table_test;
    import lpht_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_push;
    logic                   o_full;
    logic [ACTION_W-1:0]    i_action;
    logic [KEY_W-1:0]       i_key;
    logic [VALUE_WIDTH-1:0] i_new_value;
    logic                   o_empty;
    logic                   i_pop;
    logic [STATUS_W-1:0]    o_status;
    logic [VALUE_WIDTH-1:0] o_found_value;
    logic [SLOT_W-1:0]      o_slot_index;

    int                     mismatches;
    int                     outstanding;
    logic [KEY_W-1:0]       key_pool [$];
    bit                     steady_tx = 1'b0;
    bit                     steady_rx = 1'b0;
    bit                     rx_hold_req = 1'b0;

    always #4 i_clk = ~i_clk;

    linear_probe_hash_table dut (.*);

    lpht_reply_checker reply_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_full        (o_full),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_new_value   (i_new_value),
        .i_empty       (o_empty),
        .i_pop         (i_pop),
        .i_status      (o_status),
        .i_found_value (o_found_value),
        .i_slot_index  (o_slot_index),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // keep a bounded set of keys seen so later commands can hit them
    function automatic void remember_key(input logic [KEY_W-1:0] key);
        if (key_pool.size() < 64)
            key_pool = {key_pool, key};
        else
            key_pool[$urandom_range(0, 63)] = key;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (key_pool.size() != 0 && r < 60)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 70)
            return KEY_W'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] beat_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return $urandom;
    endfunction

    // offer one command beat, returns at the edge that takes it
    task automatic send_beat(input t_action act, input logic [KEY_W-1:0] key,
                             input logic [VALUE_WIDTH-1:0] val);
        int gap;
        bit took;
        gap = idle_len(steady_tx);
        if (gap > 0) begin
            i_push      <= 1'b0;
            i_action    <= ACTION_W'($urandom_range(0, 3));
            i_key       <= {$urandom, $urandom};
            i_new_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_action    <= act;
        i_key       <= key;
        i_new_value <= val;
        do begin
            @(negedge i_clk);
            took = !o_full;
            @(posedge i_clk);
        end while (!took);
    endtask

    // stop sending until every predicted reply has been popped
    task automatic drain_replies();
        i_push <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    // command side
    initial begin
        logic [KEY_W-1:0] k;
        int               r;
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_action    <= ACT_FIND;
        i_key       <= '0;
        i_new_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, key and value extremes, each action
        send_beat(ACT_FIND,     '0, 32'h1234_5678);
        send_beat(ACT_FIND_INS, '0, 32'hffff_ffff);
        send_beat(ACT_FIND,     '0, '0);
        send_beat(ACT_ASSIGN,   '0, 32'hffff_ffff);
        send_beat(ACT_ASSIGN,   '1, '0);
        send_beat(ACT_ASSIGN,   '1, 32'hffff_ffff);
        send_beat(ACT_FIND_INS, '1, '0);
        send_beat(ACT_FIND,     64'h8000_0000_0000_0000, '1);
        send_beat(ACT_ASSIGN,   64'h5555_5555_5555_5555, 32'haaaa_aaaa);
        send_beat(ACT_ASSIGN,   64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
        send_beat(ACT_FIND,     64'h5555_5555_5555_5555, '0);
        send_beat(ACT_FIND_INS, 64'haaaa_aaaa_aaaa_aaaa, '1);
        send_beat(ACT_CLEAR,    64'h0123_4567_89ab_cdef, 32'hdead_beef);
        // cleared slots come back as misses and can be claimed again
        send_beat(ACT_FIND,     '0, '0);
        send_beat(ACT_FIND,     '1, '0);
        send_beat(ACT_FIND_INS, '0, '0);
        send_beat(ACT_CLEAR,    '1, '1);
        send_beat(ACT_FIND,     '0, '0);
        drain_replies();

        // random mix over a reused key set; reply side stalls once at the start
        key_pool.delete();
        rx_hold_req = 1'b1;
        for (int n = 0; n < 430; n++) begin
            steady_tx = (n % 90) >= 70;
            if (n == 215)
                drain_replies();
            r = $urandom_range(0, 199);
            k = pick_key();
            if (r < 2) begin
                send_beat(ACT_CLEAR, k, beat_value());
            end else if (r < 60) begin
                send_beat(ACT_FIND, k, beat_value());
            end else if (r < 125) begin
                send_beat(ACT_FIND_INS, k, beat_value());
                remember_key(k);
            end else begin
                send_beat(ACT_ASSIGN, k, beat_value());
                remember_key(k);
            end
        end

        drain_replies();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // reply side
    initial begin : reply_pop
        int gap;
        int taken;
        bit took;
        bit held;
        i_pop <= 1'b0;
        taken = 0;
        held  = 1'b0;
        do @(negedge i_clk); while (!i_rst_n);
        @(posedge i_clk);
        forever begin
            // one long hold so the block backs up and stalls its input
            if (rx_hold_req && !held) begin
                held = 1'b1;
                i_pop <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = idle_len(steady_rx);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do begin
                @(negedge i_clk);
                took = !o_empty;
                @(posedge i_clk);
            end while (!took);
            taken++;
            steady_rx = (taken % 120) >= 90;
        end
    end

    // run limit
    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_front.sv
rtl/core/lpht_fifo.sv
rtl/core/lpht_back.sv
rtl/core/linear_probe_hash_table.sv
tb/lpht_reply_checker.sv
tb/linear_probe_hash_table_test.sv
